// ===== src/gcq_pkg.sv =====
// gcq_pkg: shared types and constants of the grouped class queue.
// Holds parameter defaults, operation codes, status codes and the result struct.
// No dependencies.
package gcq_pkg;

    // Parameter defaults
    localparam int NUM_CLASSES_DEF = 4;
    localparam int GROUP_DEPTH_DEF = 16;
    localparam int VALUE_BITS_DEF  = 16;

    // Fixed field widths
    localparam int CLASS_FIELD_W = 2;
    localparam int VALUE_FIELD_W = 16;

    // Operation codes
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_ACCEPTED  = 2'd0,
        ST_DELIVERED = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // Result of one transaction, minus the value that comes from the store
    typedef struct packed {
        logic                     deq;
        logic [CLASS_FIELD_W-1:0] cls;
        status_t                  status;
    } result_t;

endpackage

// ===== src/gcq_ram.sv =====
// gcq_ram: generic single-port synchronous RAM with registered read.
// Width and depth set by parameters; no reset on contents.
// No dependencies.
module gcq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read, one access per cycle
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            rdata <= mem[addr];
        end
    end

endmodule

// ===== src/gcq_ctrl.sv =====
// gcq_ctrl: group pointers, order ring and transaction decision of the grouped queue.
// Drives the item store address and write data and holds the pending result.
// Depends on gcq_pkg.
module gcq_ctrl #(
    parameter int NUM_CLASSES = 4,
    parameter int GROUP_DEPTH = 16,
    parameter int VALUE_BITS  = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    accept,
    input  logic                                    operation,
    input  logic [gcq_pkg::CLASS_FIELD_W-1:0]       class_id,
    input  logic [gcq_pkg::VALUE_FIELD_W-1:0]       item_value,
    output logic                                    ram_en,
    output logic                                    ram_we,
    output logic [$clog2(NUM_CLASSES*GROUP_DEPTH)-1:0] ram_addr,
    output logic [VALUE_BITS-1:0]                   ram_wdata,
    output logic                                    pend,
    output gcq_pkg::result_t                        res
);
    import gcq_pkg::*;

    localparam int CLS_W  = $clog2(NUM_CLASSES);
    localparam int SLOT_W = (GROUP_DEPTH > 1) ? $clog2(GROUP_DEPTH) : 1;
    localparam int CNT_W  = $clog2(GROUP_DEPTH + 1);
    localparam int OCNT_W = $clog2(NUM_CLASSES + 1);
    localparam int ADDR_W = $clog2(NUM_CLASSES * GROUP_DEPTH);

    // State
    logic [SLOT_W-1:0] group_head_reg  [NUM_CLASSES];
    logic [SLOT_W-1:0] group_head_next [NUM_CLASSES];
    logic [CNT_W-1:0]  group_count_reg [NUM_CLASSES];
    logic [CNT_W-1:0]  group_count_next[NUM_CLASSES];
    logic [CLS_W-1:0]  class_order_reg [NUM_CLASSES];
    logic [CLS_W-1:0]  class_order_next[NUM_CLASSES];
    logic [CLS_W-1:0]  order_head_reg, order_head_next;
    logic [OCNT_W-1:0] order_count_reg, order_count_next;
    logic              pend_reg, pend_next;
    result_t           res_reg, res_next;

    // Decode
    logic [CLS_W-1:0]  cidx;
    logic              cls_ok;
    logic [CLS_W-1:0]  fc;
    logic [CLS_W:0]    otail_sum;
    logic [CLS_W-1:0]  otail;
    logic [SLOT_W:0]   wslot_sum;
    logic [SLOT_W-1:0] wslot;
    logic [SLOT_W-1:0] rslot;
    logic              deq_ok;
    logic              enq_ok;
    logic              enq_new;

    assign cidx   = CLS_W'(class_id);
    assign cls_ok = (32'(class_id) < NUM_CLASSES);
    assign fc     = class_order_reg[order_head_reg];
    assign rslot  = group_head_reg[fc];

    // Tail of the order ring, wrapped at NUM_CLASSES
    assign otail_sum = (CLS_W+1)'(order_head_reg) + (CLS_W+1)'(order_count_reg);
    assign otail     = (otail_sum >= (CLS_W+1)'(NUM_CLASSES))
                     ? CLS_W'(otail_sum - (CLS_W+1)'(NUM_CLASSES))
                     : CLS_W'(otail_sum);

    // Tail slot of the target group, wrapped at GROUP_DEPTH
    assign wslot_sum = (SLOT_W+1)'(group_head_reg[cidx]) + (SLOT_W+1)'(group_count_reg[cidx]);
    assign wslot     = (wslot_sum >= (SLOT_W+1)'(GROUP_DEPTH))
                     ? SLOT_W'(wslot_sum - (SLOT_W+1)'(GROUP_DEPTH))
                     : SLOT_W'(wslot_sum);

    assign deq_ok  = (order_count_reg != '0) && (group_count_reg[fc] != '0);
    assign enq_new = (group_count_reg[cidx] == '0);
    assign enq_ok  = cls_ok
                  && (group_count_reg[cidx] < CNT_W'(GROUP_DEPTH))
                  && (!enq_new || (order_count_reg < OCNT_W'(NUM_CLASSES)));

    // Store access: write on a good enqueue, read on every dequeue
    assign ram_en    = accept;
    assign ram_we    = accept && (operation == OP_ENQ) && enq_ok;
    assign ram_addr  = (operation == OP_DEQ)
                     ? ADDR_W'(ADDR_W'(fc) * ADDR_W'(GROUP_DEPTH) + ADDR_W'(rslot))
                     : ADDR_W'(ADDR_W'(cidx) * ADDR_W'(GROUP_DEPTH) + ADDR_W'(wslot));
    assign ram_wdata = VALUE_BITS'(item_value);

    // Pointer update and result
    always_comb
    begin
        group_head_next  = group_head_reg;
        group_count_next = group_count_reg;
        class_order_next = class_order_reg;
        order_head_next  = order_head_reg;
        order_count_next = order_count_reg;
        pend_next        = accept;
        res_next         = res_reg;
        if (accept)
        begin
            res_next.deq    = 1'b0;
            res_next.cls    = '0;
            res_next.status = ST_FULL;
            if (operation == OP_DEQ)
            begin
                if (deq_ok)
                begin
                    res_next.deq    = 1'b1;
                    res_next.cls    = CLASS_FIELD_W'(fc);
                    res_next.status = ST_DELIVERED;
                    group_head_next[fc] = (rslot == SLOT_W'(GROUP_DEPTH - 1))
                                        ? '0 : SLOT_W'(rslot + 1'b1);
                    group_count_next[fc] = CNT_W'(group_count_reg[fc] - 1'b1);
                    // Class leaves the order ring when its group drains
                    if (group_count_reg[fc] == CNT_W'(1))
                    begin
                        order_head_next = (order_head_reg == CLS_W'(NUM_CLASSES - 1))
                                        ? '0 : CLS_W'(order_head_reg + 1'b1);
                        order_count_next = OCNT_W'(order_count_reg - 1'b1);
                    end
                end
                else
                begin
                    res_next.status = ST_EMPTY;
                end
            end
            else if (enq_ok)
            begin
                res_next.status = ST_ACCEPTED;
                group_count_next[cidx] = CNT_W'(group_count_reg[cidx] + 1'b1);
                // New class joins the tail of the order ring
                if (enq_new)
                begin
                    class_order_next[otail] = cidx;
                    order_count_next = OCNT_W'(order_count_reg + 1'b1);
                end
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                group_head_reg[i]  <= '0;
                group_count_reg[i] <= '0;
            end
            order_head_reg  <= '0;
            order_count_reg <= '0;
            pend_reg        <= 1'b0;
        end
        else
        begin
            group_head_reg  <= group_head_next;
            group_count_reg <= group_count_next;
            order_head_reg  <= order_head_next;
            order_count_reg <= order_count_next;
            pend_reg        <= pend_next;
        end
    end

    // Order ring contents and result payload, no reset
    always_ff @(posedge clk)
    begin
        class_order_reg <= class_order_next;
        res_reg         <= res_next;
    end

    assign pend = pend_reg;
    assign res  = res_reg;

    // Checks
    a_pend_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> pend_reg)
        else $error("accepted transaction did not raise pending result");

    a_pend_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |=> !pend_reg)
        else $error("result strobe held longer than one cycle");

    a_order_bound: assert property (@(posedge clk) disable iff (!rst_n)
        order_count_reg <= OCNT_W'(NUM_CLASSES))
        else $error("order ring overflow");

    a_enq_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation == OP_ENQ && enq_ok) |=> (order_count_reg != '0))
        else $error("accepted enqueue left the order ring empty");

    a_deliver_class: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation == OP_DEQ && deq_ok)
        |=> (res_reg.deq && res_reg.cls == CLASS_FIELD_W'($past(fc))))
        else $error("delivered class does not match front class");

endmodule

// ===== src/grouped_class_queue_top.sv =====
// grouped_class_queue_top: grouped FIFO (team queue) with per-class groups.
// Instantiates gcq_ctrl (pointers and decision) and gcq_ram (item store).
// Depends on gcq_pkg, gcq_ram, gcq_ctrl.
//
//  channel | handshake         | fields
//  --------+-------------------+-------------------------------------
//  command | start / busy      | operation, class_id, item_value
//  result  | done (strobe)     | out_class, out_value, result_status
//
// A command taken at a clock edge yields its result on the ports in the cycle after
// that edge, with done high for that one cycle; busy is high in the same cycle.
// That cycle's closing edge takes nothing, so no new command is taken while a
// result is pending; the result waits on the registered store read.
// Reset clears the group counters and heads and the order ring pointers; no clearing pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
module grouped_class_queue_top #(
    parameter int NUM_CLASSES = gcq_pkg::NUM_CLASSES_DEF,
    parameter int GROUP_DEPTH = gcq_pkg::GROUP_DEPTH_DEF,
    parameter int VALUE_BITS  = gcq_pkg::VALUE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              operation,
    input  logic [gcq_pkg::CLASS_FIELD_W-1:0] class_id,
    input  logic [gcq_pkg::VALUE_FIELD_W-1:0] item_value,
    output logic                              done,
    output logic [gcq_pkg::CLASS_FIELD_W-1:0] out_class,
    output logic [gcq_pkg::VALUE_FIELD_W-1:0] out_value,
    output logic [1:0]                        result_status
);
    import gcq_pkg::*;

    localparam int DEPTH  = NUM_CLASSES * GROUP_DEPTH;
    localparam int ADDR_W = $clog2(DEPTH);

    logic              accept;
    logic              ram_en;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [VALUE_BITS-1:0] ram_wdata;
    logic [VALUE_BITS-1:0] ram_rdata;
    logic              pend;
    result_t           res;

    // Command transaction
    assign accept = start && !busy;

    gcq_ctrl #(
        .NUM_CLASSES (NUM_CLASSES),
        .GROUP_DEPTH (GROUP_DEPTH),
        .VALUE_BITS  (VALUE_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .operation  (operation),
        .class_id   (class_id),
        .item_value (item_value),
        .ram_en     (ram_en),
        .ram_we     (ram_we),
        .ram_addr   (ram_addr),
        .ram_wdata  (ram_wdata),
        .pend       (pend),
        .res        (res)
    );

    gcq_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Result: value straight from the registered store read
    assign busy          = pend;
    assign done          = pend;
    assign out_class     = res.cls;
    assign out_value     = res.deq ? VALUE_FIELD_W'(ram_rdata) : '0;
    assign result_status = res.status;

endmodule
